[rtl/complex_spectral_difference_onset_defines.svh]
// Assertion macros used by the top level of the onset detector.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef COMPLEX_SPECTRAL_DIFFERENCE_ONSET_DEFINES_SVH
`define COMPLEX_SPECTRAL_DIFFERENCE_ONSET_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSDO_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSDO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/csdo_pkg.sv]
package csdo_pkg;

    localparam int BIN_W    = 24;
    localparam int MAG_W    = 24;
    localparam int ANG_W    = 16;
    localparam int STEPS    = 15;
    localparam int SUM_W    = 34;
    localparam int ONSET_W  = 25;
    localparam int SQ_W     = 48;
    localparam int VEC_W    = 48;
    localparam int VEC_PRE  = 20;
    localparam int ROT_W    = 34;
    localparam int ROT_Z_W  = 18;
    localparam int COS_W    = 17;
    localparam int CSD_IN_W = 50;
    localparam int CSD_W    = CSD_IN_W / 2;

    // Binary-angle arctangent table: round(atan(2^-i) * 65536 / (2*pi)).
    localparam logic [ANG_W-1:0] ANGLE_STEP [STEPS] = '{
        16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
        16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1
    };

    localparam logic [ANG_W-1:0] HALF_TURN = 16'h8000;
    localparam logic signed [ROT_W-1:0] COS_GAIN = 34'sd652032874;
    localparam logic signed [ROT_W-1:0] COS_LIMIT = 34'sd1073741824;
    localparam logic signed [ROT_W-1:0] COS_ROUND = 34'sd16384;

    typedef struct packed {
        logic [ANG_W-1:0] phase_last;
        logic [ANG_W-1:0] phase_prev;
        logic [MAG_W-1:0] mag;
    } hist_entry_t;

endpackage

[rtl/csdo_ram.sv]
module csdo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/csdo_sqrt.sv]
module csdo_sqrt #(
    parameter int IN_W = 48,
    parameter int SB_W = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid_in,
    input  logic [IN_W-1:0]       rad_in,
    input  logic [SB_W-1:0]       sb_in,
    output logic                  valid_out,
    output logic [IN_W/2-1:0]     root_out,
    output logic [SB_W-1:0]       sb_out
);

    localparam int OUT_W = IN_W / 2;
    localparam int REM_W = OUT_W + 3;

    logic              v_pipe    [OUT_W+1];
    logic [IN_W-1:0]   rad_pipe  [OUT_W+1];
    logic [REM_W-1:0]  rem_pipe  [OUT_W+1];
    logic [OUT_W-1:0]  root_pipe [OUT_W+1];
    logic [SB_W-1:0]   sb_pipe   [OUT_W+1];

    assign v_pipe[0]    = valid_in;
    assign rad_pipe[0]  = rad_in;
    assign rem_pipe[0]  = '0;
    assign root_pipe[0] = '0;
    assign sb_pipe[0]   = sb_in;

    // One result bit per stage: bring down two radicand bits, try root*4+1.
    for (genvar i = 0; i < OUT_W; i++)
    begin : g_step
        logic [REM_W-1:0] cat;
        logic [REM_W-1:0] trial;
        logic             fits;

        assign cat   = {rem_pipe[i][REM_W-3:0], rad_pipe[i][IN_W-1:IN_W-2]};
        assign trial = REM_W'({root_pipe[i], 2'b01});
        assign fits  = (cat >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_pipe[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_pipe[i+1] <= v_pipe[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_pipe[i+1]  <= rad_pipe[i] << 2;
                rem_pipe[i+1]  <= fits ? (cat - trial) : cat;
                root_pipe[i+1] <= {root_pipe[i][OUT_W-2:0], fits};
                sb_pipe[i+1]   <= sb_pipe[i];
            end
        end
    end

    assign valid_out = v_pipe[OUT_W];
    assign root_out  = root_pipe[OUT_W];
    assign sb_out    = sb_pipe[OUT_W];

endmodule

[rtl/csdo_cordic.sv]
module csdo_cordic #(
    parameter bit VECTOR = 1'b1,
    parameter int X_W    = 48,
    parameter int Z_W    = 16,
    parameter int SB_W   = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid_in,
    input  logic signed [X_W-1:0] x_in,
    input  logic signed [X_W-1:0] y_in,
    input  logic [Z_W-1:0]        z_in,
    input  logic [SB_W-1:0]       sb_in,
    output logic                  valid_out,
    output logic signed [X_W-1:0] x_out,
    output logic [Z_W-1:0]        z_out,
    output logic [SB_W-1:0]       sb_out
);

    import csdo_pkg::*;

    logic                  v_pipe  [STEPS+1];
    logic signed [X_W-1:0] x_pipe  [STEPS+1];
    logic signed [X_W-1:0] y_pipe  [STEPS+1];
    logic [Z_W-1:0]        z_pipe  [STEPS+1];
    logic [SB_W-1:0]       sb_pipe [STEPS+1];

    assign v_pipe[0]  = valid_in;
    assign x_pipe[0]  = x_in;
    assign y_pipe[0]  = y_in;
    assign z_pipe[0]  = z_in;
    assign sb_pipe[0] = sb_in;

    // Vectoring drives y toward zero; rotation drives z toward zero.
    // Both shifts use the old x and y.
    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic                  up;
        logic signed [X_W-1:0] sh_x;
        logic signed [X_W-1:0] sh_y;
        logic [Z_W-1:0]        step;

        assign sh_x = x_pipe[i] >>> i;
        assign sh_y = y_pipe[i] >>> i;
        assign step = Z_W'(ANGLE_STEP[i]);
        assign up   = VECTOR ? !y_pipe[i][X_W-1] : z_pipe[i][Z_W-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_pipe[i+1] <= 1'b0;
            end
            else if (en)
            begin
                v_pipe[i+1] <= v_pipe[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (up)
                begin
                    x_pipe[i+1] <= x_pipe[i] + sh_y;
                    y_pipe[i+1] <= y_pipe[i] - sh_x;
                    z_pipe[i+1] <= z_pipe[i] + step;
                end
                else
                begin
                    x_pipe[i+1] <= x_pipe[i] - sh_y;
                    y_pipe[i+1] <= y_pipe[i] + sh_x;
                    z_pipe[i+1] <= z_pipe[i] - step;
                end
                sb_pipe[i+1] <= sb_pipe[i];
            end
        end
    end

    assign valid_out = v_pipe[STEPS];
    assign x_out     = x_pipe[STEPS];
    assign z_out     = z_pipe[STEPS];
    assign sb_out    = sb_pipe[STEPS];

endmodule

[rtl/complex_spectral_difference_onset.sv]
// Channel  Handshake                  Payload
// bin      bin_valid / bin_stall      real_part, imag_part, last_bin
// onset    onset_valid / onset_stall  onset_value
//
// One bin is taken per cycle while bin_stall is low; the onset value of a frame
// follows the transaction that carries its last bin through the two square-root
// pipelines and the two 15-step CORDIC pipelines in series.
// After reset the bin history memory is zeroed in a pass over its FFT_SIZE/2
// entries, during which bin_stall stays high.
// A stall on the onset channel while a result waits freezes the whole pipeline.
`include "complex_spectral_difference_onset_defines.svh"

module complex_spectral_difference_onset #(
    parameter int FFT_SIZE = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                bin_valid,
    output logic                                bin_stall,
    input  logic signed [csdo_pkg::BIN_W-1:0]   real_part,
    input  logic signed [csdo_pkg::BIN_W-1:0]   imag_part,
    input  logic                                last_bin,
    output logic                                onset_valid,
    input  logic                                onset_stall,
    output logic [csdo_pkg::ONSET_W-1:0]        onset_value
);

    import csdo_pkg::*;

    localparam int HALF_BINS  = FFT_SIZE / 2;
    localparam int ADDR_W     = $clog2(HALF_BINS);
    localparam int AVG_SHIFT  = $clog2(FFT_SIZE) - 1;
    localparam int MSUM_W     = 2 * MAG_W + 1;
    localparam int PART_W     = MAG_W + 1 + COS_W;
    localparam int PC_W       = 2 * MAG_W + COS_W + 2;
    localparam int VAL_W      = PC_W + 1;
    localparam int MAG_SB_W   = 2 * BIN_W + 1 + ADDR_W;
    localparam int VEC_SB_W   = MAG_W + 1 + ADDR_W + 1;
    localparam int ROT_SB_W   = 1 + 2 * MAG_W + 2;
    localparam int HIST_W     = $bits(hist_entry_t);

    // Pipeline control.
    logic en;
    logic accept;
    logic clr_active_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] pos_next;
    logic onset_valid_reg;

    assign en        = !(onset_valid_reg && onset_stall);
    assign bin_stall = !en || clr_active_reg;
    assign accept    = bin_valid && !bin_stall;

    always_comb
    begin
        if (last_bin || pos_reg == ADDR_W'(HALF_BINS - 1))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            pos_reg        <= '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                if (clr_addr_reg == ADDR_W'(HALF_BINS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (accept)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    // Input register and squares.
    logic                    s0_valid_reg;
    logic signed [BIN_W-1:0] s0_re_reg;
    logic signed [BIN_W-1:0] s0_im_reg;
    logic                    s0_last_reg;
    logic [ADDR_W-1:0]       s0_k_reg;

    logic                    s1_valid_reg;
    logic signed [SQ_W-1:0]  s1_re2_reg;
    logic signed [SQ_W-1:0]  s1_im2_reg;
    logic [MAG_SB_W-1:0]     s1_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= accept;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_re_reg   <= real_part;
            s0_im_reg   <= imag_part;
            s0_last_reg <= last_bin;
            s0_k_reg    <= pos_reg;
            s1_re2_reg  <= s0_re_reg * s0_re_reg;
            s1_im2_reg  <= s0_im_reg * s0_im_reg;
            s1_sb_reg   <= {s0_re_reg, s0_im_reg, s0_last_reg, s0_k_reg};
        end
    end

    // Magnitude.
    logic                mq_valid;
    logic [MAG_W-1:0]    mq_mag;
    logic [MAG_SB_W-1:0] mq_sb;
    logic [SQ_W-1:0]     mag_rad;

    assign mag_rad = SQ_W'(s1_re2_reg + s1_im2_reg);

    csdo_sqrt #(
        .IN_W (SQ_W),
        .SB_W (MAG_SB_W)
    ) u_mag_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (s1_valid_reg),
        .rad_in    (mag_rad),
        .sb_in     (s1_sb_reg),
        .valid_out (mq_valid),
        .root_out  (mq_mag),
        .sb_out    (mq_sb)
    );

    // Phase by CORDIC vectoring; the left half plane is turned by half a turn first.
    logic signed [BIN_W-1:0] mq_re;
    logic signed [BIN_W-1:0] mq_im;
    logic                    mq_last;
    logic [ADDR_W-1:0]       mq_k;
    logic signed [VEC_W-1:0] vx_scaled;
    logic signed [VEC_W-1:0] vy_scaled;
    logic signed [VEC_W-1:0] vx_in;
    logic signed [VEC_W-1:0] vy_in;
    logic [ANG_W-1:0]        vz_in;
    logic                    mq_zero;

    assign {mq_re, mq_im, mq_last, mq_k} = mq_sb;
    assign vx_scaled = VEC_W'(mq_re) <<< VEC_PRE;
    assign vy_scaled = VEC_W'(mq_im) <<< VEC_PRE;
    assign vx_in     = mq_re[BIN_W-1] ? -vx_scaled : vx_scaled;
    assign vy_in     = mq_re[BIN_W-1] ? -vy_scaled : vy_scaled;
    assign vz_in     = mq_re[BIN_W-1] ? HALF_TURN : '0;
    assign mq_zero   = (mq_re == '0) && (mq_im == '0);

    logic                vo_valid;
    logic [ANG_W-1:0]    vo_z;
    logic [VEC_SB_W-1:0] vo_sb;
    logic [MAG_W-1:0]    vo_mag;
    logic                vo_last;
    logic [ADDR_W-1:0]   vo_k;
    logic                vo_zero;

    csdo_cordic #(
        .VECTOR (1'b1),
        .X_W    (VEC_W),
        .Z_W    (ANG_W),
        .SB_W   (VEC_SB_W)
    ) u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (mq_valid),
        .x_in      (vx_in),
        .y_in      (vy_in),
        .z_in      (vz_in),
        .sb_in     ({mq_mag, mq_last, mq_k, mq_zero}),
        .valid_out (vo_valid),
        .x_out     (),
        .z_out     (vo_z),
        .sb_out    (vo_sb)
    );

    assign {vo_mag, vo_last, vo_k, vo_zero} = vo_sb;

    // History lookup. The read is issued here and the entry is rewritten from the
    // m1 registers; the last write is forwarded because the read taken at the
    // same edge does not see it.
    logic                m1_valid_reg;
    logic [ANG_W-1:0]    m1_ph_reg;
    logic [MAG_W-1:0]    m1_mag_reg;
    logic                m1_last_reg;
    logic [ADDR_W-1:0]   m1_k_reg;

    logic                fwd_valid_reg;
    logic [ADDR_W-1:0]   fwd_addr_reg;
    hist_entry_t         fwd_data_reg;

    logic [HIST_W-1:0]   ram_rdata;
    hist_entry_t         hist;
    hist_entry_t         hist_new;
    logic [ANG_W-1:0]    dev;
    logic                fold;
    logic [ANG_W-1:0]    dev_folded;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [HIST_W-1:0]   ram_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg <= vo_valid;
            if (m1_valid_reg)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_ph_reg   <= vo_zero ? '0 : vo_z;
            m1_mag_reg  <= vo_mag;
            m1_last_reg <= vo_last;
            m1_k_reg    <= vo_k;
            if (m1_valid_reg)
            begin
                fwd_addr_reg <= m1_k_reg;
                fwd_data_reg <= hist_new;
            end
        end
    end

    always_comb
    begin
        if (fwd_valid_reg && fwd_addr_reg == m1_k_reg)
        begin
            hist = fwd_data_reg;
        end
        else
        begin
            hist = hist_entry_t'(ram_rdata);
        end
        hist_new.phase_last = m1_ph_reg;
        hist_new.phase_prev = hist.phase_last;
        hist_new.mag        = m1_mag_reg;
        dev        = m1_ph_reg - (hist.phase_last << 1) + hist.phase_prev;
        // Angles in the left half are turned by half a turn; the cosine's
        // sign is flipped afterwards.
        fold       = dev[ANG_W-1] ^ dev[ANG_W-2];
        dev_folded = fold ? (dev + HALF_TURN) : dev;
    end

    assign ram_we    = clr_active_reg || (en && m1_valid_reg);
    assign ram_waddr = clr_active_reg ? clr_addr_reg : m1_k_reg;
    assign ram_wdata = clr_active_reg ? '0 : HIST_W'(hist_new);

    csdo_ram #(
        .WIDTH (HIST_W),
        .DEPTH (HALF_BINS)
    ) u_hist (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (en),
        .rd_addr (vo_k),
        .rd_data (ram_rdata)
    );

    // Deviation register ahead of the cosine.
    logic                      m2_valid_reg;
    logic signed [ROT_Z_W-1:0] m2_z_reg;
    logic [ROT_SB_W-1:0]       m2_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_z_reg  <= ROT_Z_W'($signed(dev_folded));
            m2_sb_reg <= {fold, m1_mag_reg, hist.mag, (m1_mag_reg > hist.mag), m1_last_reg};
        end
    end

    // Cosine by CORDIC rotation.
    logic                    ro_valid;
    logic signed [ROT_W-1:0] ro_x;
    logic [ROT_SB_W-1:0]     ro_sb;
    logic [ROT_Z_W-1:0]      ro_z_unused;

    csdo_cordic #(
        .VECTOR (1'b0),
        .X_W    (ROT_W),
        .Z_W    (ROT_Z_W),
        .SB_W   (ROT_SB_W)
    ) u_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (m2_valid_reg),
        .x_in      (COS_GAIN),
        .y_in      ('0),
        .z_in      (m2_z_reg),
        .sb_in     (m2_sb_reg),
        .valid_out (ro_valid),
        .x_out     (ro_x),
        .z_out     (ro_z_unused),
        .sb_out    (ro_sb)
    );

    logic                    ro_neg;
    logic [MAG_W-1:0]        ro_mag;
    logic [MAG_W-1:0]        ro_prev;
    logic                    ro_gt;
    logic                    ro_last;
    logic signed [ROT_W-1:0] cos_clamped;
    logic signed [ROT_W-1:0] cos_rounded;
    logic signed [COS_W-1:0] cos_abs;

    assign {ro_neg, ro_mag, ro_prev, ro_gt, ro_last} = ro_sb;

    always_comb
    begin
        if (ro_x > COS_LIMIT)
        begin
            cos_clamped = COS_LIMIT;
        end
        else if (ro_x < -COS_LIMIT)
        begin
            cos_clamped = -COS_LIMIT;
        end
        else
        begin
            cos_clamped = ro_x;
        end
        cos_rounded = (cos_clamped + COS_ROUND) >>> 15;
        cos_abs     = cos_rounded[COS_W-1:0];
    end

    // Law of cosines: m^2 + p^2 - 2*m*p*cos, with m*p*c split in two halves.
    logic                    c1_valid_reg;
    logic signed [COS_W-1:0] c1_cos_reg;
    logic [MAG_W-1:0]        c1_mag_reg;
    logic [MAG_W-1:0]        c1_prev_reg;
    logic                    c1_gt_reg;
    logic                    c1_last_reg;

    logic                    p1_valid_reg;
    logic [2*MAG_W-1:0]      p1_prod_reg;
    logic [2*MAG_W-1:0]      p1_msq_reg;
    logic [2*MAG_W-1:0]      p1_psq_reg;
    logic signed [COS_W-1:0] p1_cos_reg;
    logic [1:0]              p1_flags_reg;

    logic                     p2_valid_reg;
    logic signed [PART_W-1:0] p2_lo_reg;
    logic signed [PART_W-1:0] p2_hi_reg;
    logic [MSUM_W-1:0]        p2_msum_reg;
    logic [1:0]               p2_flags_reg;

    logic                   p3_valid_reg;
    logic signed [PC_W-1:0] p3_pc_reg;
    logic [MSUM_W-1:0]      p3_msum_reg;
    logic [1:0]             p3_flags_reg;

    logic                   p4_valid_reg;
    logic [CSD_IN_W-1:0]    p4_rad_reg;
    logic [1:0]             p4_flags_reg;

    logic signed [VAL_W-1:0] val;

    assign val = VAL_W'($signed({1'b0, p3_msum_reg})) - VAL_W'(p3_pc_reg >>> 14);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_valid_reg <= ro_valid;
            p1_valid_reg <= c1_valid_reg;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_cos_reg   <= ro_neg ? -cos_abs : cos_abs;
            c1_mag_reg   <= ro_mag;
            c1_prev_reg  <= ro_prev;
            c1_gt_reg    <= ro_gt;
            c1_last_reg  <= ro_last;

            p1_prod_reg  <= c1_mag_reg * c1_prev_reg;
            p1_msq_reg   <= c1_mag_reg * c1_mag_reg;
            p1_psq_reg   <= c1_prev_reg * c1_prev_reg;
            p1_cos_reg   <= c1_cos_reg;
            p1_flags_reg <= {c1_gt_reg, c1_last_reg};

            p2_lo_reg    <= $signed({1'b0, p1_prod_reg[MAG_W-1:0]}) * p1_cos_reg;
            p2_hi_reg    <= $signed({1'b0, p1_prod_reg[2*MAG_W-1:MAG_W]}) * p1_cos_reg;
            p2_msum_reg  <= MSUM_W'(p1_msq_reg) + MSUM_W'(p1_psq_reg);
            p2_flags_reg <= p1_flags_reg;

            p3_pc_reg    <= (PC_W'(p2_hi_reg) <<< MAG_W) + PC_W'(p2_lo_reg);
            p3_msum_reg  <= p2_msum_reg;
            p3_flags_reg <= p2_flags_reg;

            p4_rad_reg   <= val[VAL_W-1] ? '0 : val[CSD_IN_W-1:0];
            p4_flags_reg <= p3_flags_reg;
        end
    end

    // Complex distance.
    logic             sq_valid;
    logic [CSD_W-1:0] sq_csd;
    logic             sq_gt;
    logic             sq_last;

    csdo_sqrt #(
        .IN_W (CSD_IN_W),
        .SB_W (2)
    ) u_csd_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (p4_valid_reg),
        .rad_in    (p4_rad_reg),
        .sb_in     (p4_flags_reg),
        .valid_out (sq_valid),
        .root_out  (sq_csd),
        .sb_out    ({sq_gt, sq_last})
    );

    // Frame sum and output register.
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   sum_upd;
    logic [SUM_W-1:0]   avg_full;
    logic [ONSET_W-1:0] avg_sat;
    logic [ONSET_W-1:0] onset_value_reg;

    always_comb
    begin
        sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(sq_csd);
        if (!sq_gt)
        begin
            sum_upd = sum_reg;
        end
        else if (sum_add[SUM_W])
        begin
            sum_upd = '1;
        end
        else
        begin
            sum_upd = sum_add[SUM_W-1:0];
        end
        avg_full = sum_upd >> AVG_SHIFT;
        avg_sat  = (|avg_full[SUM_W-1:ONSET_W]) ? '1 : avg_full[ONSET_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg         <= '0;
            onset_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            onset_valid_reg <= sq_valid && sq_last;
            if (sq_valid)
            begin
                sum_reg <= sq_last ? '0 : sum_upd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && sq_valid && sq_last)
        begin
            onset_value_reg <= avg_sat;
        end
    end

    assign onset_valid = onset_valid_reg;
    assign onset_value = onset_value_reg;

    `CSDO_ASSERT_NEXT(a_pos_restart, accept && last_bin, pos_reg == '0,
        "bin position did not restart after a last bin")
    `CSDO_ASSERT_NEXT(a_sum_cleared, en && sq_valid && sq_last, sum_reg == '0,
        "frame sum not cleared after the frame result")
    `CSDO_ASSERT_SAME(a_clear_idle, clr_active_reg, !s0_valid_reg && !m1_valid_reg,
        "bin in flight during the history clearing pass")
    `CSDO_ASSERT_NEXT(a_emit_on_last, en && sq_valid && sq_last, onset_valid_reg,
        "frame result not presented after its last bin")

endmodule

[sim/complex_spectral_difference_onset_test.sv]
module complex_spectral_difference_onset_test;
    timeunit 1ns;
    timeprecision 1ps;

    import csdo_pkg::*;

    localparam int HALF_BINS = 512;
    localparam int AVG_SHIFT = 9;
    localparam longint unsigned SUM_CEIL = 64'h3_FFFF_FFFF;
    localparam longint unsigned ONSET_CEIL = 64'h1FF_FFFF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD = 300;

    logic                       clk;
    logic                       rst_n;
    logic                       bin_valid;
    logic                       bin_stall;
    logic signed [BIN_W-1:0]    real_part;
    logic signed [BIN_W-1:0]    imag_part;
    logic                       last_bin;
    logic                       onset_valid;
    logic                       onset_stall;
    logic [ONSET_W-1:0]         onset_value;

    complex_spectral_difference_onset uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .bin_valid   (bin_valid),
        .bin_stall   (bin_stall),
        .real_part   (real_part),
        .imag_part   (imag_part),
        .last_bin    (last_bin),
        .onset_valid (onset_valid),
        .onset_stall (onset_stall),
        .onset_value (onset_value)
    );

    // Predicted detector state.
    logic [ANG_W-1:0]   phase_hist1 [HALF_BINS];
    logic [ANG_W-1:0]   phase_hist2 [HALF_BINS];
    logic [MAG_W-1:0]   mag_hist [HALF_BINS];
    int                 next_bin;
    longint unsigned    distance_sum;

    logic [ONSET_W-1:0] onset_queue [$];
    int                 error_count;
    int                 idle_pct;
    int                 stall_pct;
    bit                 hold_request;
    int                 hold_left;
    int                 quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [ANG_W-1:0] bin_phase(longint re, longint im);
        longint x;
        longint y;
        longint dx;
        longint dy;
        logic [ANG_W-1:0] a;
        if (re == 0 && im == 0)
            return '0;
        x = re * 64'sd1048576;
        y = im * 64'sd1048576;
        a = '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            a = HALF_TURN;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                a = a + ANGLE_STEP[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                a = a - ANGLE_STEP[i];
            end
        end
        return a;
    endfunction

    function automatic longint cosine_q15(logic [ANG_W-1:0] ang);
        logic [ANG_W-1:0] u;
        bit flip;
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        longint c;
        u = ang;
        flip = 1'b0;
        if (u >= 16'd16384 && u < 16'd49152)
        begin
            u = u + HALF_TURN;
            flip = 1'b1;
        end
        z = longint'($signed(u));
        x = longint'(COS_GAIN);
        y = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - int'(ANGLE_STEP[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + int'(ANGLE_STEP[i]);
            end
        end
        if (x > longint'(COS_LIMIT))
            x = longint'(COS_LIMIT);
        if (x < -longint'(COS_LIMIT))
            x = -longint'(COS_LIMIT);
        c = (x + longint'(COS_ROUND)) >>> 15;
        return flip ? -c : c;
    endfunction

    function automatic void clear_history();
        for (int i = 0; i < HALF_BINS; i++)
        begin
            phase_hist1[i] = '0;
            phase_hist2[i] = '0;
            mag_hist[i] = '0;
        end
        next_bin = 0;
        distance_sum = 0;
    endfunction

    function automatic void predict_onset(logic signed [BIN_W-1:0] re_in,
                                          logic signed [BIN_W-1:0] im_in,
                                          logic last);
        longint re;
        longint im;
        longint m;
        longint p;
        longint c;
        longint val;
        longint unsigned avg;
        logic [ANG_W-1:0] ph;
        logic [ANG_W-1:0] dev;
        int k;
        re = re_in;
        im = im_in;
        k = next_bin;
        m = longint'(int_sqrt(longint'(re * re + im * im)));
        p = longint'(mag_hist[k]);
        ph = bin_phase(re, im);
        dev = ph - (phase_hist1[k] << 1) + phase_hist2[k];
        if (m > p)
        begin
            c = cosine_q15(dev);
            val = m * m + p * p - ((m * p * c) >>> 14);
            distance_sum = distance_sum + int_sqrt(val > 0 ? val : 0);
            if (distance_sum > SUM_CEIL)
                distance_sum = SUM_CEIL;
        end
        phase_hist2[k] = phase_hist1[k];
        phase_hist1[k] = ph;
        mag_hist[k] = m[MAG_W-1:0];
        next_bin = (k + 1) % HALF_BINS;
        if (last)
        begin
            avg = distance_sum >> AVG_SHIFT;
            if (avg > ONSET_CEIL)
                avg = ONSET_CEIL;
            onset_queue = {onset_queue, avg[ONSET_W-1:0]};
            distance_sum = 0;
            next_bin = 0;
        end
    endfunction

    task automatic send_bin(logic signed [BIN_W-1:0] re, logic signed [BIN_W-1:0] im,
                            logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            bin_valid <= 1'b0;
            @(posedge clk);
        end
        bin_valid <= 1'b1;
        real_part <= re;
        imag_part <= im;
        last_bin <= last;
        do
            @(posedge clk);
        while (bin_stall);
        predict_onset(re, im, last);
    endtask

    function automatic logic signed [BIN_W-1:0] random_field();
        case ($urandom_range(3))
            0: return 24'($urandom);
            1: return $signed(24'($urandom_range(2047))) - 24'sd1024;
            2: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            default: return $signed(24'($urandom_range(262143))) - 24'sd131072;
        endcase
    endfunction

    task automatic send_frame(int len);
        for (int i = 0; i < len; i++)
            send_bin(random_field(), random_field(), i == len - 1);
    endtask

    task automatic test_extremes();
        logic signed [BIN_W-1:0] edge_vals [4];
        edge_vals = '{24'sh800000, 24'sh7FFFFF, 24'sh000000, 24'sh000001};
        idle_pct = 0;
        stall_pct = 0;
        // Single-bin frames, so every value lands on bin zero and the
        // magnitude both rises and falls from one value to the next.
        foreach (edge_vals[i])
            foreach (edge_vals[j])
                send_bin(edge_vals[i], edge_vals[j], 1'b1);
        // Bins falling from frame to frame add nothing to the sum.
        send_bin(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
        send_bin(24'sh400000, 24'sh000000, 1'b1);
        send_bin(24'sh000010, 24'sh000010, 1'b0);
        send_bin(24'sh000000, 24'sh000000, 1'b1);
    endtask

    task automatic test_overlong_frame();
        // Runs past the history depth so bin positions wrap around.
        idle_pct = 0;
        stall_pct = 0;
        send_frame(HALF_BINS + 12);
    endtask

    task automatic test_random_frames();
        int idle_mix [4];
        int stall_mix [4];
        int sent;
        int len;
        idle_mix = '{0, 58, 0, 25};
        stall_mix = '{0, 0, 58, 25};
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = idle_mix[ph];
            stall_pct = stall_mix[ph];
            sent = 0;
            while (sent < 85)
            begin
                len = $urandom_range(4) == 0 ? $urandom_range(60, 20) : $urandom_range(1, 12);
                send_frame(len);
                sent += len;
            end
        end
    endtask

    task automatic test_output_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_request = 1'b1;
        for (int i = 0; i < 60; i++)
            send_frame($urandom_range(1, 3));
    endtask

    // Receiver side: random stall, plus a long hold when requested.
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            onset_stall <= 1'b1;
        end
        else
            onset_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && onset_valid && !onset_stall)
        begin
            if (onset_queue.size() == 0)
            begin
                $display("%0t: unexpected onset transaction, value %0d", $time, onset_value);
                error_count++;
            end
            else
            begin
                if (onset_value !== onset_queue[0])
                begin
                    $display("%0t: onset_value expected %0d actual %0d", $time,
                             onset_queue[0], onset_value);
                    error_count++;
                end
                void'(onset_queue.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((bin_valid && !bin_stall) || (onset_valid && !onset_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("complex_spectral_difference_onset_test: errors");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        bin_valid = 1'b0;
        real_part = '0;
        imag_part = '0;
        last_bin = 1'b0;
        onset_stall = 1'b0;
        hold_request = 1'b0;
        hold_left = 0;
        quiet_cycles = 0;
        error_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        clear_history();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_overlong_frame();
        test_random_frames();
        test_output_backpressure();

        bin_valid <= 1'b0;
        while (onset_queue.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        if (error_count == 0)
            $display("complex_spectral_difference_onset_test: clean");
        else
            $display("complex_spectral_difference_onset_test: errors");
        $finish;
    end
endmodule
